// ===== design/ccsf_pkg.sv =====
// Shared types and constants of the control character strip filter.
`default_nettype none

package ccsf_pkg;

    // Byte and mask types.
    typedef logic [7:0]  t_char;
    typedef logic [63:0] t_mask_word;
    typedef logic [1:0]  t_row;

    // Bytes with a special meaning in the filter.
    localparam t_char COLOUR_BYTE = 8'h03;
    localparam t_char ESCAPE_BYTE = 8'h1B;
    localparam t_char COMMA_BYTE  = 8'h2C;
    localparam t_char DIGIT_LOW   = 8'h30;
    localparam t_char DIGIT_HIGH  = 8'h39;

    // Reset contents of the strip mask: colour and escape bytes in the first row.
    localparam t_mask_word MASK_RESET_ROW0 =
        (64'd1 << COLOUR_BYTE[5:0]) | (64'd1 << ESCAPE_BYTE[5:0]);
    localparam int MASK_ROWS = 4;

    // Colour code parser phase, one-hot.
    typedef enum logic [4:0] {
        PH_NORMAL       = 5'b00001,
        PH_AFTER_COLOUR = 5'b00010,
        PH_FG1          = 5'b00100,
        PH_FG2          = 5'b01000,
        PH_BG1          = 5'b10000
    } t_phase;

    // One result beat.
    typedef struct packed {
        t_char out_char;
        logic  has_char;
        logic  end_of_message;
    } t_result;

    // Up to two results produced by one input beat.
    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Reset value of one mask row.
    function automatic t_mask_word mask_reset(input t_row row);
        t_mask_word word;
        case (row)
            2'd0:    word = MASK_RESET_ROW0;
            default: word = '0;
        endcase
        return word;
    endfunction

endpackage

`default_nettype wire

// ===== design/ccsf_in_if.sv =====
// Input channel of the strip filter: one message byte per beat.
`default_nettype none

interface ccsf_in_if;
    logic             valid;
    logic             ready;
    ccsf_pkg::t_char  in_char;
    logic             strip_enable;
    logic             last_byte;

    modport source (output valid, output in_char, output strip_enable,
                    output last_byte, input ready);
    modport sink   (input valid, input in_char, input strip_enable,
                    input last_byte, output ready);
endinterface

`default_nettype wire

// ===== design/ccsf_out_if.sv =====
// Output channel of the strip filter: one kept byte or end marker per beat.
`default_nettype none

interface ccsf_out_if;
    logic             valid;
    logic             ready;
    ccsf_pkg::t_char  out_char;
    logic             has_char;
    logic             end_of_message;

    modport source (output valid, output out_char, output has_char,
                    output end_of_message, input ready);
    modport sink   (input valid, input out_char, input has_char,
                    input end_of_message, output ready);
endinterface

`default_nettype wire

// ===== design/ccsf_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module ccsf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                          i_wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// ===== design/ccsf_mask_store.sv =====
// Strip mask store: mask RAM with per-row valid bits and reset values.
`default_nettype none

module ccsf_mask_store (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_wr_en,
    input  wire ccsf_pkg::t_row        i_wr_row,
    input  wire ccsf_pkg::t_mask_word  i_wr_data,
    input  wire ccsf_pkg::t_row        i_rd_row,
    output ccsf_pkg::t_mask_word       o_rd_data,
    output logic                       o_comma_strip
);
    import ccsf_pkg::*;

    // Reset contents of the row that holds the comma's strip bit.
    localparam t_mask_word COMMA_ROW_RESET = mask_reset(COMMA_BYTE[7:6]);

    logic [MASK_ROWS-1:0] r_row_valid;
    logic                 r_rd_valid;
    t_row                 r_rd_row;
    t_mask_word           ram_q;

    ccsf_ram #(
        .WIDTH ($bits(t_mask_word)),
        .DEPTH (MASK_ROWS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_row),
        .i_wr_data (i_wr_data),
        .i_rd_addr (i_rd_row),
        .o_rd_data (ram_q)
    );

    // A row reads as its reset value until it has been written once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_wr_en) begin
            r_row_valid[i_wr_row] <= 1'b1;
        end
    end

    // Row valid bit and address travel alongside the RAM read.
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_row_valid[i_rd_row];
        r_rd_row   <= i_rd_row;
    end

    assign o_rd_data = r_rd_valid ? ram_q : mask_reset(r_rd_row);

    // The comma strip bit is needed at any time, so it is shadowed in a flop.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_comma_strip <= COMMA_ROW_RESET[COMMA_BYTE[5:0]];
        end else if (i_wr_en && (i_wr_row == COMMA_BYTE[7:6])) begin
            o_comma_strip <= i_wr_data[COMMA_BYTE[5:0]];
        end
    end

endmodule

`default_nettype wire

// ===== design/ccsf_out_queue.sv =====
// Result queue: takes up to two result beats per cycle, issues one while the output side is ready.
`default_nettype none

module ccsf_out_queue #(
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ccsf_pkg::t_push          i_push,
    output logic [$clog2(DEPTH+1)-1:0]    o_count,
    ccsf_out_if.source                    o_out
);
    import ccsf_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH+1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_head;
    logic [PTR_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   tail_next;
    logic               pop;

    assign tail_next = r_tail + PTR_W'(1);
    assign pop       = o_out.valid && o_out.ready;

    // Storage writes: first result at the tail, second just after it.
    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_tail] <= i_push.r0;
        end
        if (i_push.n == 2'd2) begin
            r_mem[tail_next] <= i_push.r1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + PTR_W'(i_push.n);
            r_head  <= r_head + PTR_W'(pop);
            r_count <= r_count + CNT_W'(i_push.n) - CNT_W'(pop);
        end
    end

    assign o_count              = r_count;
    assign o_out.valid          = (r_count != '0);
    assign o_out.out_char       = r_mem[r_head].out_char;
    assign o_out.has_char       = r_mem[r_head].has_char;
    assign o_out.end_of_message = r_mem[r_head].end_of_message;

    // The fill level never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue fill level beyond depth");

    // Room was reserved upstream, so a push always fits.
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.n != 2'd0) |->
            ({1'b0, r_count} + (CNT_W+1)'(i_push.n) <= (CNT_W+1)'(DEPTH)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// ===== design/control_char_strip_filter_core.sv =====
// Top level of the control character strip filter.
// Accepts one message byte per cycle. The byte's mask row is read from a
// four-row mask RAM in the cycle of acceptance; the next cycle looks up the
// strip bit, steps the colour code parser and writes up to two result beats
// into a result queue, from which they are offered on the output. Input is
// taken every cycle while each byte yields at most one result and the output
// side takes a beat each cycle; a byte that yields two results (a released
// comma and a kept byte) puts both into the queue, and the input stalls when
// the queue has no room for two more results beyond those already in flight.
// Mask rows read as their reset values until written, so no clearing pass
// follows reset. The user must write mask words through the configuration
// port only while the filter is idle; the block itself does not enforce it.
`default_nettype none

module control_char_strip_filter_core #(
    parameter int QUEUE_DEPTH = 8   // power of two, at least 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire ccsf_pkg::t_row        i_cfg_idx,
    input  wire ccsf_pkg::t_mask_word  i_cfg_data,
    ccsf_in_if.sink                    i_in,
    ccsf_out_if.source                 o_out
);
    import ccsf_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic               accept;
    logic [CNT_W-1:0]   q_count;
    logic [CNT_W:0]     room_need;
    t_mask_word         row_bits;
    logic               comma_strip;

    logic               r_s1_valid;
    t_char              r_s1_char;
    logic               r_s1_en;
    logic               r_s1_last;
    t_phase             r_phase;
    logic               r_held;
    t_phase             n_phase;
    logic               n_held;

    logic               strip_c;
    logic               is_digit;
    logic               is_comma;
    logic               plain_keep;
    t_phase             plain_phase;
    logic               pre;
    logic               main;
    logic               post;
    logic               hold_set;
    logic [1:0]         cnt;
    t_push              push;

    // Input handshake: room for the beat in stage one and for this beat.
    assign room_need = {1'b0, q_count} + (CNT_W+1)'(r_s1_valid ? 4 : 2);
    assign i_in.ready = (room_need <= (CNT_W+1)'(QUEUE_DEPTH));
    assign accept     = i_in.valid && i_in.ready;

    ccsf_mask_store u_mask (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr_en       (i_cfg_we),
        .i_wr_row      (i_cfg_idx),
        .i_wr_data     (i_cfg_data),
        .i_rd_row      (i_in.in_char[7:6]),
        .o_rd_data     (row_bits),
        .o_comma_strip (comma_strip)
    );

    // Stage one holds the byte while its mask row is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_char <= i_in.in_char;
            r_s1_en   <= i_in.strip_enable;
            r_s1_last <= i_in.last_byte;
        end
    end

    // Byte classification and plain-text handling.
    always_comb begin
        strip_c     = row_bits[r_s1_char[5:0]];
        is_digit    = r_s1_char inside {[DIGIT_LOW:DIGIT_HIGH]};
        is_comma    = (r_s1_char == COMMA_BYTE);
        plain_keep  = !strip_c;
        plain_phase = (strip_c && (r_s1_char == COLOUR_BYTE)) ? PH_AFTER_COLOUR
                                                               : PH_NORMAL;
    end

    // Colour code parser. A comma is released before the byte (pre) or,
    // on the last byte, after a comma that would otherwise be held (post).
    always_comb begin
        pre      = 1'b0;
        main     = 1'b0;
        post     = 1'b0;
        hold_set = 1'b0;
        n_phase  = r_phase;
        n_held   = r_held;
        if (r_s1_valid) begin
            if (!r_s1_en) begin
                pre     = r_held && !comma_strip;
                main    = 1'b1;
                n_held  = 1'b0;
                n_phase = PH_NORMAL;
            end else if (r_held) begin
                n_held = 1'b0;
                if (is_digit) begin
                    n_phase = PH_BG1;
                end else begin
                    pre     = !comma_strip;
                    main    = plain_keep;
                    n_phase = plain_phase;
                end
            end else begin
                case (r_phase)
                    PH_AFTER_COLOUR: begin
                        if (is_digit) begin
                            n_phase = PH_FG1;
                        end else begin
                            main    = plain_keep;
                            n_phase = plain_phase;
                        end
                    end
                    PH_FG1: begin
                        if (is_digit) begin
                            n_phase = PH_FG2;
                        end else if (is_comma) begin
                            hold_set = 1'b1;
                            n_phase  = PH_NORMAL;
                        end else begin
                            main    = plain_keep;
                            n_phase = plain_phase;
                        end
                    end
                    PH_FG2: begin
                        if (is_comma) begin
                            hold_set = 1'b1;
                            n_phase  = PH_NORMAL;
                        end else begin
                            main    = plain_keep;
                            n_phase = plain_phase;
                        end
                    end
                    PH_BG1: begin
                        if (is_digit) begin
                            n_phase = PH_NORMAL;
                        end else begin
                            main    = plain_keep;
                            n_phase = plain_phase;
                        end
                    end
                    default: begin
                        main    = plain_keep;
                        n_phase = plain_phase;
                    end
                endcase
            end
            if (hold_set) begin
                n_held = 1'b1;
            end
            post = r_s1_last && hold_set && !comma_strip;
            if (r_s1_last) begin
                n_phase = PH_NORMAL;
                n_held  = 1'b0;
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_held  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    // Result beats for the queue; an empty end marker when nothing of the last byte is kept.
    always_comb begin
        cnt = {1'b0, pre} + {1'b0, main} + {1'b0, post};
        push.r0.has_char       = (cnt != 2'd0);
        push.r0.out_char       = (cnt == 2'd0) ? '0 :
                                 (pre || !main) ? COMMA_BYTE : r_s1_char;
        push.r0.end_of_message = r_s1_last && (cnt != 2'd2);
        push.r1.has_char       = 1'b1;
        push.r1.out_char       = r_s1_char;
        push.r1.end_of_message = r_s1_last;
        if (!r_s1_valid) begin
            push.n = 2'd0;
        end else if (cnt == 2'd0) begin
            push.n = r_s1_last ? 2'd1 : 2'd0;
        end else begin
            push.n = cnt;
        end
    end

    ccsf_out_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_count (q_count),
        .o_out   (o_out)
    );

    // The last byte of a message leaves the parser in normal text.
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |=> ((r_phase == PH_NORMAL) && !r_held))
        else $error("parser state not cleared after last byte");

    // With stripping off, no comma is ever held.
    a_off_no_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !r_s1_en) |=> !r_held)
        else $error("comma held while stripping is off");

    // The last byte always yields at least one result beat.
    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> (push.n != 2'd0))
        else $error("last byte produced no result");

endmodule

`default_nettype wire
